### design/prq_pkg.sv
// Shared types and constants for the packet retransmit queue.
`default_nettype none
package prq_pkg;
  localparam int unsigned DepthDefault   = 32;
  localparam int unsigned KeepMaxDefault = 8;

  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_PEEK   = 3'd2,
    FN_LOOKUP = 3'd3,
    FN_TRUNC  = 3'd4,
    FN_KEEP   = 3'd5,
    FN_FILTER = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] handle;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;
endpackage
`default_nettype wire

### design/prq_in_if.sv
// Input channel: one queue operation per transfer.
`default_nettype none
interface prq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] pkt_id;
  logic [31:0] pkt_handle;
  logic [15:0] pkt_length;
  logic [5:0]  position;
  logic        clear_set;

  modport source (output valid, func, pkt_id, pkt_handle, pkt_length, position, clear_set,
                  input ready);
  modport sink (input valid, func, pkt_id, pkt_handle, pkt_length, position, clear_set,
                output ready);
endinterface
`default_nettype wire

### design/prq_out_if.sv
// Output channel: one result item per transfer.
`default_nettype none
interface prq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic [31:0] out_handle;
  logic [15:0] out_length;
  logic [4:0]  out_index;
  logic [5:0]  occupancy;
  logic        last;

  modport source (output valid, status, out_id, out_handle, out_length, out_index,
                  occupancy, last, input ready);
  modport sink (input valid, status, out_id, out_handle, out_length, out_index,
                occupancy, last, output ready);
endinterface
`default_nettype wire

### design/prq_cell.sv
// One queue cell: holds an entry, loads new data or takes its neighbor's entry.
`default_nettype none
module prq_cell (
  input  wire logic                clk_i,
  input  wire prq_pkg::cell_ctrl_t ctrl_i,
  input  wire prq_pkg::entry_t     nbr_i,
  input  wire prq_pkg::entry_t     load_i,
  output prq_pkg::entry_t          data_o
);
  import prq_pkg::*;

  entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= load_i;
    end else if (ctrl_i.shift) begin
      data_q <= nbr_i;
    end
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

### design/packet_retransmit_queue_top.sv
// Top level of the packet retransmit queue: cell row, keep set and sequencer.
//
//  channel | dir | handshake           | payload
//  in_i    | in  | valid/ready         | func, pkt_id, pkt_handle, pkt_length, position, clear_set
//  out_o   | out | valid/ready         | status, out_id, out_handle, out_length, out_index,
//          |     |                     | occupancy, last
//
// Push, pop, peek, truncate and keep are done in idle with a registered result. Lookup rotates the
// cell row once around, then gives its result. Filter rotates once to count survivors, then steps
// once per queued entry, putting survivors back at the tail and sending out each dropped entry.
// Reset clears the count, keep count, sequencer and output valid; cell contents are not reset.
// A stalled output holds filter drops and the result state; input needs idle and a free output.
`default_nettype none
module packet_retransmit_queue_top #(
  parameter int unsigned DEPTH    = prq_pkg::DepthDefault,
  parameter int unsigned KEEP_MAX = prq_pkg::KeepMaxDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prq_in_if.sink    in_i,
  prq_out_if.source out_o
);
  import prq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = $clog2(KEEP_MAX + 1);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, step_q, step_d, tot_q, tot_d, nkeep_q, nkeep_d;
  logic [CW-1:0] rem_q, rem_d, fidx_q, fidx_d, ld_pos;
  logic [KW-1:0] kcnt_q, kcnt_d, kc, kw;
  logic          keep_we, found_q, found_d, ld_en, sh, hit, acc, out_free, filt_go;
  logic          scan_last, fstep_last, inr, ov_q, ov_d;
  logic [15:0]   keep_q [KEEP_MAX];
  logic [15:0]   id_q, id_d;
  func_e         func_q, func_d;
  entry_t        fent_q, fent_d, ld_data, head;
  entry_t        cell_out [DEPTH];
  cell_ctrl_t    ctrl [DEPTH];
  status_e       ost_q, ost_d;
  entry_t        oent_q, oent_d;
  logic [4:0]    oidx_q, oidx_d;
  logic [5:0]    oocc_q, oocc_d;
  logic          olast_q, olast_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].shift = sh;
    assign ctrl[i].load  = ld_en && (ld_pos == CW'(i));
    prq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl[i]),
      .nbr_i  (cell_out[(i + 1) % DEPTH]),
      .load_i (ld_data),
      .data_o (cell_out[i])
    );
  end

  assign head       = cell_out[0];
  assign acc        = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign scan_last  = step_q == CW'(DEPTH - 1);
  assign fstep_last = step_q == tot_q - CW'(1);
  assign inr        = step_q < cnt_q;
  assign filt_go    = (state_q == S_FILT) && (hit || out_free);

  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < KEEP_MAX; j++) begin
      if ((KW'(j) < kcnt_q) && (keep_q[j] == head.id)) hit = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && (in_i.func == FN_LOOKUP || in_i.func == FN_FILTER)) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) begin
          if (func_q == FN_FILTER && nkeep_d != cnt_q) state_d = S_FILT;
          else state_d = S_RESP;
        end
      end
      S_FILT: begin
        if (filt_go && fstep_last) state_d = S_IDLE;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    cnt_d = cnt_q; step_d = step_q; tot_d = tot_q; nkeep_d = nkeep_q; rem_d = rem_q;
    fidx_d = fidx_q; found_d = found_q; fent_d = fent_q; kcnt_d = kcnt_q;
    id_d = id_q; func_d = func_q;
    kc = kcnt_q; kw = kcnt_q; keep_we = 1'b0;
    sh = 1'b0; ld_en = 1'b0; ld_pos = cnt_q; ld_data = '0;
    ov_d = ov_q && !out_o.ready;
    ost_d = ost_q; oent_d = oent_q; oidx_d = oidx_q; oocc_d = oocc_q; olast_d = olast_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          func_d  = func_e'(in_i.func);
          id_d    = in_i.pkt_id;
          step_d  = '0;
          found_d = 1'b0;
          nkeep_d = '0;
          ost_d   = ST_NONE;
          oent_d  = '0;
          oidx_d  = '0;
          olast_d = 1'b1;
          ov_d    = 1'b1;
          case (func_e'(in_i.func))
            FN_PUSH: begin
              if (int'(cnt_q) < int'(DEPTH)) begin
                ld_en   = 1'b1;
                ld_data = '{id: in_i.pkt_id, handle: in_i.pkt_handle, length: in_i.pkt_length};
                cnt_d   = cnt_q + CW'(1);
                ost_d   = ST_OK;
              end else begin
                ost_d = ST_FULL;
              end
            end
            FN_POP: begin
              if (cnt_q != '0) begin
                sh     = 1'b1;
                cnt_d  = cnt_q - CW'(1);
                ost_d  = ST_OK;
                oent_d = head;
              end
            end
            FN_PEEK: begin
              if (cnt_q != '0) begin
                ost_d  = ST_OK;
                oent_d = head;
              end
            end
            FN_TRUNC: begin
              if (int'(in_i.position) < int'(cnt_q)) begin
                cnt_d = CW'(in_i.position);
                ost_d = ST_OK;
              end
            end
            FN_KEEP: begin
              kc = in_i.clear_set ? '0 : kcnt_q;
              kcnt_d = kc;
              if (int'(kc) >= int'(KEEP_MAX)) begin
                ost_d = ST_FULL;
              end else begin
                keep_we = 1'b1;
                kw      = kc;
                kcnt_d  = kc + KW'(1);
                ost_d   = ST_OK;
              end
            end
            FN_LOOKUP, FN_FILTER: ov_d = 1'b0;
            default: ost_d = ST_NONE;
          endcase
          oocc_d = 6'(cnt_d);
        end
      end
      S_SCAN: begin
        // Rotate the whole row once; the head cell sees each position in turn.
        sh     = 1'b1;
        step_d = step_q + CW'(1);
        if (func_q == FN_LOOKUP && inr && !found_q && head.id == id_q) begin
          found_d = 1'b1;
          fent_d  = head;
          fidx_d  = step_q;
        end
        if (func_q == FN_FILTER && inr && hit) nkeep_d = nkeep_q + CW'(1);
        if (scan_last) begin
          step_d = '0;
          tot_d  = cnt_q;
          rem_d  = '0;
        end
      end
      S_FILT: begin
        if (filt_go) begin
          // Drop the head; a survivor goes back in at the tail.
          sh     = 1'b1;
          step_d = step_q + CW'(1);
          if (hit) begin
            ld_en   = 1'b1;
            ld_pos  = cnt_q - CW'(1);
            ld_data = head;
          end else begin
            cnt_d   = cnt_q - CW'(1);
            rem_d   = rem_q + CW'(1);
            ov_d    = 1'b1;
            ost_d   = ST_OK;
            oent_d  = head;
            oidx_d  = '0;
            oocc_d  = 6'(nkeep_q);
            olast_d = (rem_q + CW'(1)) == (tot_q - nkeep_q);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          olast_d = 1'b1;
          oocc_d  = 6'(cnt_q);
          if (func_q == FN_LOOKUP && found_q) begin
            ost_d  = ST_OK;
            oent_d = fent_q;
            oidx_d = 5'(fidx_q);
          end else begin
            ost_d  = ST_NONE;
            oent_d = '0;
            oidx_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      kcnt_q  <= '0;
      ov_q    <= 1'b0;
      step_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      kcnt_q  <= kcnt_d;
      ov_q    <= ov_d;
      step_q  <= step_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q   <= tot_d;
    nkeep_q <= nkeep_d;
    rem_q   <= rem_d;
    fidx_q  <= fidx_d;
    fent_q  <= fent_d;
    id_q    <= id_d;
    func_q  <= func_d;
    ost_q   <= ost_d;
    oent_q  <= oent_d;
    oidx_q  <= oidx_d;
    oocc_q  <= oocc_d;
    olast_q <= olast_d;
    for (int j = 0; j < KEEP_MAX; j++) begin
      if (keep_we && kw == KW'(j)) keep_q[j] <= id_d;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.status     = ost_q;
  assign out_o.out_id     = oent_q.id;
  assign out_o.out_handle = oent_q.handle;
  assign out_o.out_length = oent_q.length;
  assign out_o.out_index  = oidx_q;
  assign out_o.occupancy  = oocc_q;
  assign out_o.last       = olast_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= int'(DEPTH)) else $error("entry count above depth");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == S_IDLE) else $error("input ready outside idle");
  a_filt_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILT |=> cnt_q <= $past(cnt_q)) else $error("filter grew the queue");
  a_keep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(kcnt_q) <= int'(KEEP_MAX)) else $error("keep count above limit");
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the packet retransmit queue: random and directed operations checked against a model.
`timescale 1ns / 100ps
module testbench;
  import prq_pkg::*;

  localparam int Depth   = 32;
  localparam int KeepMax = 8;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] pkt_id;
    logic [31:0] pkt_handle;
    logic [15:0] pkt_length;
    logic [5:0]  position;
    logic        clear_set;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [31:0] out_handle;
    logic [15:0] out_length;
    logic [4:0]  out_index;
    logic [5:0]  occupancy;
    logic        last;
  } res_t;

  logic clk_i, rst_ni;
  prq_in_if  in_if();
  prq_out_if out_if();

  packet_retransmit_queue_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source)
  );

  op_t    pending_ops[$];
  res_t   expected_results[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off = 0;
  int     idle_cycles = 0;

  // queue model
  entry_t      q_mem[Depth];
  int          q_head, q_count;
  logic [15:0] keep_mem[KeepMax];
  int          keep_cnt;
  logic [15:0] live_ids[$];

  function automatic res_t mk(logic [1:0] st, entry_t e, int idx, logic lst);
    res_t r;
    r.status = st;
    r.out_id = e.id;
    r.out_handle = e.handle;
    r.out_length = e.length;
    r.out_index = idx[4:0];
    r.occupancy = q_count[5:0];
    r.last = lst;
    return r;
  endfunction

  task automatic predict_queue_op(op_t op);
    entry_t e, none;
    entry_t removed[$];
    int s, nkeep;
    logic hit, found;
    none = '0;
    case (op.func)
      FN_PUSH: begin
        if (q_count >= Depth) expected_results.push_back(mk(ST_FULL, none, 0, 1'b1));
        else begin
          e.id = op.pkt_id; e.handle = op.pkt_handle; e.length = op.pkt_length;
          q_mem[(q_head + q_count) % Depth] = e;
          q_count++;
          expected_results.push_back(mk(ST_OK, none, 0, 1'b1));
        end
      end
      FN_POP: begin
        if (q_count == 0) expected_results.push_back(mk(ST_NONE, none, 0, 1'b1));
        else begin
          e = q_mem[q_head];
          q_count--;
          q_head = (q_count == 0) ? 0 : (q_head + 1) % Depth;
          expected_results.push_back(mk(ST_OK, e, 0, 1'b1));
        end
      end
      FN_PEEK: begin
        if (q_count == 0) expected_results.push_back(mk(ST_NONE, none, 0, 1'b1));
        else expected_results.push_back(mk(ST_OK, q_mem[q_head], 0, 1'b1));
      end
      FN_LOOKUP: begin
        found = 1'b0;
        for (int i = 0; i < q_count; i++) begin
          s = (q_head + i) % Depth;
          if (!found && q_mem[s].id == op.pkt_id) begin
            found = 1'b1;
            expected_results.push_back(mk(ST_OK, q_mem[s], i, 1'b1));
          end
        end
        if (!found) expected_results.push_back(mk(ST_NONE, none, 0, 1'b1));
      end
      FN_TRUNC: begin
        if (op.position < q_count) begin
          q_count = op.position;
          if (q_count == 0) q_head = 0;
          expected_results.push_back(mk(ST_OK, none, 0, 1'b1));
        end else expected_results.push_back(mk(ST_NONE, none, 0, 1'b1));
      end
      FN_KEEP: begin
        if (op.clear_set) keep_cnt = 0;
        if (keep_cnt >= KeepMax) expected_results.push_back(mk(ST_FULL, none, 0, 1'b1));
        else begin
          keep_mem[keep_cnt] = op.pkt_id;
          keep_cnt++;
          expected_results.push_back(mk(ST_OK, none, 0, 1'b1));
        end
      end
      FN_FILTER: begin
        nkeep = 0;
        for (int i = 0; i < q_count; i++) begin
          s = (q_head + i) % Depth;
          hit = 1'b0;
          for (int j = 0; j < keep_cnt; j++) if (keep_mem[j] == q_mem[s].id) hit = 1'b1;
          if (hit) begin
            q_mem[(q_head + nkeep) % Depth] = q_mem[s];
            nkeep++;
          end else removed.push_back(q_mem[s]);
        end
        q_count = nkeep;
        if (q_count == 0) q_head = 0;
        if (removed.size() == 0) expected_results.push_back(mk(ST_NONE, none, 0, 1'b1));
        foreach (removed[k])
          expected_results.push_back(mk(ST_OK, removed[k], 0, k == removed.size() - 1));
      end
      default: expected_results.push_back(mk(ST_NONE, none, 0, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic op_t rand_op(int kind);
    op_t op;
    op.func = kind[2:0];
    op.pkt_id = (live_ids.size() > 0 && $urandom_range(0, 1))
                ? live_ids[$urandom_range(0, live_ids.size() - 1)] : 16'($urandom);
    op.pkt_handle = $urandom;
    op.pkt_length = 16'($urandom);
    op.position = 6'($urandom_range(0, 63));
    op.clear_set = $urandom_range(0, 3) == 0;
    return op;
  endfunction

  task automatic add_op(logic [2:0] f, logic [15:0] id, logic [31:0] h, logic [15:0] l,
                        logic [5:0] p, logic c);
    op_t op;
    op.func = f; op.pkt_id = id; op.pkt_handle = h; op.pkt_length = l;
    op.position = p; op.clear_set = c;
    if (live_ids.size() < 16) live_ids.push_back(id);
    pending_ops.push_back(op);
  endtask

  task automatic fill_random(int n);
    int k;
    op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40) op = rand_op(FN_PUSH);
      else if (k < 50) op = rand_op(FN_POP);
      else if (k < 56) op = rand_op(FN_PEEK);
      else if (k < 68) op = rand_op(FN_LOOKUP);
      else if (k < 74) begin
        op = rand_op(FN_TRUNC);
        op.position = 6'($urandom_range(0, 40));
      end
      else if (k < 88) op = rand_op(FN_KEEP);
      else if (k < 98) op = rand_op(FN_FILTER);
      else op = rand_op(7);
      if (op.func == FN_PUSH && live_ids.size() < 16) live_ids.push_back(op.pkt_id);
      pending_ops.push_back(op);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_queue_op(pending_ops.pop_front());
      if ((!in_if.valid || in_if.ready) ) begin
        if (pending_ops.size() > (in_if.valid && in_if.ready ? 0 : 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.valid      <= 1'b1;
          in_if.func       <= pending_ops[0].func;
          in_if.pkt_id     <= pending_ops[0].pkt_id;
          in_if.pkt_handle <= pending_ops[0].pkt_handle;
          in_if.pkt_length <= pending_ops[0].pkt_length;
          in_if.position   <= pending_ops[0].position;
          in_if.clear_set  <= pending_ops[0].clear_set;
        end else in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.status, out_if.out_id, out_if.out_handle, out_if.out_length,
               out_if.out_index, out_if.occupancy, out_if.last};
        if (expected_results.size() == 0) report_mismatch("unexpected result", got.out_id, 0);
        else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.out_id !== want.out_id) report_mismatch("out_id", got.out_id, want.out_id);
          if (got.out_handle !== want.out_handle)
            report_mismatch("out_handle", got.out_handle, want.out_handle);
          if (got.out_length !== want.out_length)
            report_mismatch("out_length", got.out_length, want.out_length);
          if (got.out_index !== want.out_index)
            report_mismatch("out_index", got.out_index, want.out_index);
          if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", got.occupancy, want.occupancy);
          if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        end
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_if.ready <= 1'b0;
      end else out_if.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (2 * Depth + 10) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.func = '0; in_if.pkt_id = '0; in_if.pkt_handle = '0;
    in_if.pkt_length = '0; in_if.position = '0; in_if.clear_set = 1'b0;
    out_if.ready = 1'b0;
    q_head = 0; q_count = 0; keep_cnt = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, extremes, every operation
    add_op(FN_POP, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_PEEK, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_LOOKUP, 16'h1234, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_TRUNC, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_FILTER, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_PUSH, 16'hffff, 32'hffffffff, 16'hffff, 6'd63, 1'b1);
    add_op(FN_PUSH, 16'h0000, 32'h00000000, 16'h0000, 6'd0, 1'b0);
    add_op(FN_PUSH, 16'h00aa, 32'h5555aaaa, 16'h0102, 6'd0, 1'b0);
    add_op(FN_LOOKUP, 16'h00aa, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_PEEK, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_TRUNC, 16'h0, 32'h0, 16'h0, 6'd32, 1'b0);
    add_op(FN_TRUNC, 16'h0, 32'h0, 16'h0, 6'd3, 1'b0);
    add_op(3'd7, 16'hffff, 32'hffffffff, 16'hffff, 6'd63, 1'b1);
    // filter with an empty keep set drops all
    add_op(FN_FILTER, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_PUSH, 16'h0001, 32'h1, 16'h1, 6'd0, 1'b0);
    add_op(FN_PUSH, 16'h0002, 32'h2, 16'h2, 6'd0, 1'b0);
    for (int i = 0; i < 9; i++) add_op(FN_KEEP, 16'(i), 32'h0, 16'h0, 6'd0, i == 0);
    add_op(FN_FILTER, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    wait_drained();

    // fill to full then overflow, with a long receiver hold-off
    for (int i = 0; i < 34; i++) add_op(FN_PUSH, 16'(100 + i), $urandom, 16'($urandom), 6'd0, 0);
    hold_off = 300;
    add_op(FN_POP, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_PUSH, 16'h7777, 32'h7777, 16'h7, 6'd0, 1'b0);
    add_op(FN_LOOKUP, 16'h7777, 32'h0, 16'h0, 6'd0, 1'b0);
    add_op(FN_KEEP, 16'd101, 32'h0, 16'h0, 6'd0, 1'b1);
    add_op(FN_FILTER, 16'h0, 32'h0, 16'h0, 6'd0, 1'b0);
    wait_drained();

    send_idle_pct = 0;  recv_stall_pct = 0;  fill_random(15); wait_drained();
    send_idle_pct = 88; recv_stall_pct = 0;  fill_random(15); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 88; fill_random(15); wait_drained();
    send_idle_pct = 14; recv_stall_pct = 14; fill_random(15); wait_drained();

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
